[src/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants for the 4:2:0 chroma box downsampler
// Field widths, register map and register reset values used by the block
// and its port checker.
// ----------------------------------------------------------------------------
package cds_pkg;

   // payload field widths
   localparam int SAMPLE_W = 8;
   localparam int PAIR_W   = 9;
   localparam int SUM_W    = 10;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 11;

   // configuration register widths
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;

   // register port
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;

   // register map, word index taken from the byte address
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // register reset values
   localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

   // smallest frame dimension
   localparam int MIN_DIM = 2;

endpackage

[src/cds_ram.sv]
// ----------------------------------------------------------------------------
// cds_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module cds_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/chroma_downsample_420_box_top.sv]
// ----------------------------------------------------------------------------
// chroma_downsample_420_box_top: 4:2:0 chroma subsampling by 2x2 box sum
// Even rows store horizontal pair sums in a half-line buffer; odd rows add
// the stored sum to the current pair and emit the four-sample sum (8.2).
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_sample
//   rsp_      out        rsp_valid/rsp_stall  rsp_block_sum, rsp_out_col,
//                                             rsp_out_row, rsp_frame_end
//   csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One request is taken every cycle unless req_stall is raised. The request
// that completes a block passes through the read stage, which waits for the
// line buffer read, and then the final add into the output register.
// The line buffer has one write and one read port; even rows only write it
// and odd rows only read it, so the two never meet on one entry.
// Synchronous reset clears the counters, the held left sample and the valid
// flags; the line buffer is not cleared and is filled by the first even row.
// A stalled result holds the output; the read stage behind it then stalls
// requests only once it is occupied as well.
// ----------------------------------------------------------------------------
module chroma_downsample_420_box_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cds_pkg::SAMPLE_W-1:0]        req_sample,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cds_pkg::SUM_W-1:0]           rsp_block_sum,
   output logic [cds_pkg::COL_W-1:0]           rsp_out_col,
   output logic [cds_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                rsp_frame_end,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cds_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [cds_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [cds_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                pready
);

   // counter and buffer sizing
   localparam int WC           = $clog2(MAX_WIDTH);
   localparam int WR           = $clog2(MAX_HEIGHT);
   localparam int WCW          = $clog2(MAX_WIDTH + 1);
   localparam int WRW          = $clog2(MAX_HEIGHT + 1);
   localparam int LINE_ENTRIES = (MAX_WIDTH + 1) / 2;
   localparam int AW           = (LINE_ENTRIES > 1) ? $clog2(LINE_ENTRIES) : 1;

   // configuration registers
   logic [cds_pkg::CFG_WIDTH_W-1:0]  cfg_width_ff;
   logic [cds_pkg::CFG_HEIGHT_W-1:0] cfg_height_ff;
   logic                             cfg_wr;
   cds_pkg::reg_index_type           cfg_idx;

   // effective frame size
   logic [WCW-1:0] w_eff;
   logic [WRW-1:0] h_eff;

   // position and left sample
   logic [WC-1:0]                col_ff, col_in;
   logic [WR-1:0]                row_ff, row_in;
   logic [cds_pkg::SAMPLE_W-1:0] left_ff, left_in;

   // request stage
   logic                       req_acc;
   logic [cds_pkg::PAIR_W-1:0] pair_sum;
   logic [WC-1:0]              pair_idx;
   logic [WR-1:0]              orow;
   logic [AW-1:0]              ram_addr;
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [cds_pkg::PAIR_W-1:0] ram_rd_data;
   logic                       col_last;
   logic                       row_last;
   logic                       block_last;

   // read stage
   logic                       s1_valid_ff, s1_valid_in;
   logic [cds_pkg::PAIR_W-1:0] s1_pair_ff;
   logic [cds_pkg::COL_W-1:0]  s1_col_ff;
   logic [cds_pkg::ROW_W-1:0]  s1_row_ff;
   logic                       s1_last_ff;
   logic                       s1_move;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cds_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic [cds_pkg::COL_W-1:0]  rsp_col_ff;
   logic [cds_pkg::ROW_W-1:0]  rsp_row_ff;
   logic                       rsp_end_ff;
   logic                       rsp_free;

   // register write decode
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_idx = cds_pkg::reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= cds_pkg::RESET_WIDTH;
         cfg_height_ff <= cds_pkg::RESET_HEIGHT;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            cds_pkg::REG_FRAME_WIDTH: begin
               cfg_width_ff <= pwdata[cds_pkg::CFG_WIDTH_W-1:0];
            end
            cds_pkg::REG_FRAME_HEIGHT: begin
               cfg_height_ff <= pwdata[cds_pkg::CFG_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (cfg_idx)
         cds_pkg::REG_FRAME_WIDTH:  prdata = cds_pkg::APB_DATA_W'(cfg_width_ff);
         cds_pkg::REG_FRAME_HEIGHT: prdata = cds_pkg::APB_DATA_W'(cfg_height_ff);
         default:                   prdata = '0;
      endcase
   end

   // clamp the frame size into the supported range
   always_comb begin
      priority if (32'(cfg_width_ff) < 32'(cds_pkg::MIN_DIM)) begin
         w_eff = WCW'(cds_pkg::MIN_DIM);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(32'(cfg_width_ff));
      end
      priority if (32'(cfg_height_ff) < 32'(cds_pkg::MIN_DIM)) begin
         h_eff = WRW'(cds_pkg::MIN_DIM);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = WRW'(MAX_HEIGHT);
      end else begin
         h_eff = WRW'(32'(cfg_height_ff));
      end
   end

   // handshake: the output frees up when empty or taken
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_stall = s1_valid_ff && !rsp_free;
   assign req_acc   = req_valid && !req_stall;

   // request stage: pair sum, buffer access, end of line, row and frame
   assign pair_sum   = cds_pkg::PAIR_W'(left_ff) + cds_pkg::PAIR_W'(req_sample);
   assign pair_idx   = col_ff >> 1;
   assign orow       = row_ff >> 1;
   assign ram_addr   = AW'(pair_idx);
   assign ram_wr_en  = req_acc && col_ff[0] && !row_ff[0];
   assign ram_rd_en  = req_acc && col_ff[0] && row_ff[0];
   assign col_last   = (WCW'(col_ff) + WCW'(1)) >= w_eff;
   assign row_last   = (WRW'(row_ff) + WRW'(1)) >= h_eff;
   assign block_last = ((WRW'(orow) + WRW'(1)) == (h_eff >> 1))
                    && ((WCW'(pair_idx) + WCW'(1)) == (w_eff >> 1));

   // position counters and left sample
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (req_acc) begin
         if (!col_ff[0]) begin
            left_in = req_sample;
         end
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + WR'(1);
         end else begin
            col_in = col_ff + WC'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= left_in;
      end
   end

   // half-line buffer of pair sums
   cds_ram #(
      .WIDTH (cds_pkg::PAIR_W),
      .DEPTH (LINE_ENTRIES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (pair_sum),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // read stage: waits for the stored pair sum
   always_comb begin
      priority if (ram_rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (ram_rd_en) begin
         s1_pair_ff <= pair_sum;
         s1_col_ff  <= cds_pkg::COL_W'(pair_idx);
         s1_row_ff  <= cds_pkg::ROW_W'(orow);
         s1_last_ff <= block_last;
      end
   end

   // output register: four-sample sum
   always_comb begin
      priority if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_move) begin
         rsp_sum_ff <= cds_pkg::SUM_W'(s1_pair_ff) + cds_pkg::SUM_W'(ram_rd_data);
         rsp_col_ff <= s1_col_ff;
         rsp_row_ff <= s1_row_ff;
         rsp_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_sum = rsp_sum_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

[src/cds_checker.sv]
// ----------------------------------------------------------------------------
// cds_checker: port-level checks for the 4:2:0 chroma box downsampler
// Watches the request and result channels of the top level and is bound to
// it below.
// ----------------------------------------------------------------------------
module cds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [cds_pkg::SUM_W-1:0]    rsp_block_sum,
   input logic [cds_pkg::COL_W-1:0]    rsp_out_col,
   input logic [cds_pkg::ROW_W-1:0]    rsp_out_row,
   input logic                         rsp_frame_end
);

   logic req_acc;

   assign req_acc = req_valid && !req_stall;

   // a stalled result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_block_sum) && $stable(rsp_out_col)
                                 && $stable(rsp_out_row) && $stable(rsp_frame_end))
      else $error("stalled result payload changed");

   // reset empties the output
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a fresh result follows an accepted request through the read stage and the output register
   a_rsp_latency : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_acc, 2))
      else $error("result without matching request");

endmodule

bind chroma_downsample_420_box_top cds_checker u_cds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_block_sum (rsp_block_sum),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_row   (rsp_out_row),
   .rsp_frame_end (rsp_frame_end)
);
